// ===== sv/pud_pkg.sv =====
package pud_pkg;

    // One request on the input channel: a raw byte of the encoded string.
    typedef struct packed {
        logic [7:0] char_in;
        logic       is_final;
    } in_t;

    // One decoded byte on the result channel.
    typedef struct packed {
        logic [7:0] byte_out;
        logic       run_last;
        logic       string_end;
    } out_t;

    // A single input byte can produce at most three decoded bytes.
    localparam int unsigned MAX_RUN = 3;

    typedef logic [1:0] run_cnt_t;

    // The decoded bytes caused by one input request, in emission order.
    typedef struct packed {
        run_cnt_t                  count;
        logic [MAX_RUN-1:0][7:0]   run_bytes;
        logic                      fin;
    } run_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PERCENT = 2'd1,
        PH_DIGIT   = 2'd2
    } phase_t;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h37;
        end else if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

// ===== sv/pud_front.sv =====
module pud_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  pud_pkg::in_t    s_payload,
    output logic            push_valid,
    input  logic            push_ready,
    output pud_pkg::run_t   push_data
);

    pud_pkg::phase_t   phase_reg, phase_next;
    logic [7:0]        held_reg, held_next;
    logic              accept;
    logic              c_hex;
    logic [7:0]        c;
    logic              fin;
    logic              plain;
    pud_pkg::run_cnt_t cnt;
    logic [pud_pkg::MAX_RUN-1:0][7:0] slots;

    assign c       = s_payload.char_in;
    assign fin     = s_payload.is_final;
    assign c_hex   = pud_pkg::is_hex(c);
    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    // Escape tracking.
    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept) begin
            case (phase_reg)
                pud_pkg::PH_PERCENT: begin
                    if (c_hex) begin
                        phase_next = pud_pkg::PH_DIGIT;
                        held_next  = c;
                    end else if (c == pud_pkg::CH_PERCENT) begin
                        phase_next = pud_pkg::PH_PERCENT;
                    end else begin
                        phase_next = pud_pkg::PH_IDLE;
                    end
                end
                pud_pkg::PH_DIGIT: begin
                    held_next = '0;
                    if (!c_hex && c == pud_pkg::CH_PERCENT) begin
                        phase_next = pud_pkg::PH_PERCENT;
                    end else begin
                        phase_next = pud_pkg::PH_IDLE;
                    end
                end
                default: begin
                    if (c == pud_pkg::CH_PERCENT) begin
                        phase_next = pud_pkg::PH_PERCENT;
                    end else begin
                        phase_next = pud_pkg::PH_IDLE;
                    end
                end
            endcase
            if (fin) begin
                phase_next = pud_pkg::PH_IDLE;
                held_next  = '0;
            end
        end
    end

    // Build the run of decoded bytes that this request produces.
    always_comb begin
        cnt   = '0;
        slots = '0;
        plain = 1'b1;
        case (phase_reg)
            pud_pkg::PH_PERCENT: begin
                if (c_hex) begin
                    plain = 1'b0;
                end else begin
                    slots[cnt] = pud_pkg::CH_PERCENT;
                    cnt        = cnt + 2'd1;
                end
            end
            pud_pkg::PH_DIGIT: begin
                if (c_hex) begin
                    plain      = 1'b0;
                    slots[cnt] = {pud_pkg::hex_value(held_reg), pud_pkg::hex_value(c)};
                    cnt        = cnt + 2'd1;
                end else begin
                    slots[cnt] = pud_pkg::CH_PERCENT;
                    cnt        = cnt + 2'd1;
                    slots[cnt] = held_reg;
                    cnt        = cnt + 2'd1;
                end
            end
            default: begin
            end
        endcase
        if (plain && c != pud_pkg::CH_PERCENT) begin
            slots[cnt] = (c == pud_pkg::CH_PLUS) ? pud_pkg::CH_SPACE : c;
            cnt        = cnt + 2'd1;
        end
        // At the end of a string any open escape is flushed literally.
        if (fin) begin
            if (phase_reg == pud_pkg::PH_PERCENT && c_hex) begin
                slots[cnt] = pud_pkg::CH_PERCENT;
                cnt        = cnt + 2'd1;
                slots[cnt] = c;
                cnt        = cnt + 2'd1;
            end else if (plain && c == pud_pkg::CH_PERCENT) begin
                slots[cnt] = pud_pkg::CH_PERCENT;
                cnt        = cnt + 2'd1;
            end
        end
    end

    assign push_valid          = accept && (cnt != '0);
    assign push_data.count     = cnt;
    assign push_data.run_bytes = slots;
    assign push_data.fin       = fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pud_pkg::PH_IDLE;
            held_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== sv/pud_queue.sv =====
module pud_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  pud_pkg::run_t push_data,
    input  logic          pop,
    output logic          head_valid,
    output pud_pkg::run_t head_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pud_pkg::run_t   mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue occupancy exceeds its depth");

    a_head_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> head_data.count != '0)
        else $error("queue holds a run with no bytes");

endmodule

// ===== sv/pud_back.sv =====
module pud_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  pud_pkg::run_t head_data,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output pud_pkg::out_t m_payload
);

    logic              m_valid_reg, m_valid_next;
    pud_pkg::out_t     m_data_reg, m_data_next;
    pud_pkg::run_cnt_t idx_reg, idx_next;
    logic              load;
    logic              last;

    assign last = (idx_reg == head_data.count - 2'd1);
    assign load = head_valid && (!m_valid_reg || m_ready);
    assign pop  = load && last;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        idx_next     = idx_reg;
        if (load) begin
            m_valid_next           = 1'b1;
            m_data_next.byte_out   = head_data.run_bytes[idx_reg];
            m_data_next.run_last   = last;
            m_data_next.string_end = last && head_data.fin;
            idx_next               = last ? '0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> idx_reg < head_data.count)
        else $error("byte index runs past the current run");

    a_idx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> idx_reg == '0)
        else $error("byte index not rewound while no run is pending");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.string_end |-> m_data_reg.run_last)
        else $error("string end flagged on a byte that does not close its run");

endmodule

// ===== sv/percent_url_decoder_unit.sv =====
// Decoded bytes are written into the queue and then loaded into the output register.
// Throughput: one input request per clock while the queue has room; the output side sends one decoded
// byte per clock while the consumer accepts, so the 0 to 3 bytes of one request leave one at a time.
// A queue of QUEUE_DEPTH runs between the classifier and the output stage absorbs such bursts.
// Reset: synchronous, active low on aresetn; no escape is pending and the queue is empty after it.
module percent_url_decoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pud_pkg::in_t  s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output pud_pkg::out_t m_payload
);

    // The front end tracks the escape state and turns each input request into a run of
    // zero to three decoded bytes. Requests that only open or extend an escape produce no
    // run and never touch the queue.
    logic          push_valid;
    logic          push_ready;
    pud_pkg::run_t push_data;

    // The queue decouples classification from emission, so a stalled consumer only blocks
    // the input once the queue is full.
    logic          head_valid;
    pud_pkg::run_t head_data;
    logic          pop;

    pud_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // The back end walks the run at the queue head into the output register one byte per clock while
    // the consumer accepts, marking the last byte of each run and the final byte of the string.
    pud_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule

// ===== verif/percent_url_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module percent_url_decoder_unit_tb;

    import pud_pkg::*;

    // Tracks the decoder's escape state and holds, in order, every decoded
    // byte that the accepted requests so far must still produce.
    class url_decode_scoreboard;
        out_t            pending_bytes[$];
        phase_t          phase;
        logic [7:0]      held_digit;
        logic [7:0]      run_bytes[$];
        int unsigned     fail_count;
        int unsigned     request_count;
        int unsigned     result_count;

        function new();
            phase         = PH_IDLE;
            held_digit    = 8'h00;
            fail_count    = 0;
            request_count = 0;
            result_count  = 0;
        endfunction

        // Bit 4 flags an ASCII hex digit and bits 3:0 hold its value.
        function logic [4:0] decode_nibble(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) begin
                return {1'b1, c[3:0]};
            end
            if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
                return {1'b1, c[3:0] + 4'd9};
            end
            return 5'b0;
        endfunction

        function void take_plain(logic [7:0] c);
            if (c == CH_PERCENT) begin
                phase = PH_PERCENT;
            end else if (c == CH_PLUS) begin
                run_bytes.push_back(CH_SPACE);
            end else begin
                run_bytes.push_back(c);
            end
        endfunction

        function void note_request(in_t req);
            logic [4:0] digit;
            logic [4:0] first;
            out_t       item;
            run_bytes.delete();
            request_count++;
            digit = decode_nibble(req.char_in);
            case (phase)
                PH_PERCENT: begin
                    if (digit[4]) begin
                        held_digit = req.char_in;
                        phase      = PH_DIGIT;
                    end else begin
                        run_bytes.push_back(CH_PERCENT);
                        phase = PH_IDLE;
                        take_plain(req.char_in);
                    end
                end
                PH_DIGIT: begin
                    if (digit[4]) begin
                        first = decode_nibble(held_digit);
                        run_bytes.push_back({first[3:0], digit[3:0]});
                    end else begin
                        run_bytes.push_back(CH_PERCENT);
                        run_bytes.push_back(held_digit);
                    end
                    phase      = PH_IDLE;
                    held_digit = 8'h00;
                    if (!digit[4]) begin
                        take_plain(req.char_in);
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    take_plain(req.char_in);
                end
            endcase
            if (req.is_final) begin
                if (phase == PH_PERCENT) begin
                    run_bytes.push_back(CH_PERCENT);
                end else if (phase == PH_DIGIT) begin
                    run_bytes.push_back(CH_PERCENT);
                    run_bytes.push_back(held_digit);
                end
                phase      = PH_IDLE;
                held_digit = 8'h00;
            end
            foreach (run_bytes[i]) begin
                item.byte_out   = run_bytes[i];
                item.run_last   = (i == run_bytes.size() - 1);
                item.string_end = item.run_last && req.is_final;
                pending_bytes.push_back(item);
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            result_count++;
            if (pending_bytes.size() == 0) begin
                $error("decoded byte %02h arrived with nothing outstanding", got.byte_out);
                fail_count++;
                return;
            end
            want = pending_bytes.pop_front();
            if (got.byte_out !== want.byte_out) begin
                $error("byte_out: expected %02h, got %02h", want.byte_out, got.byte_out);
                fail_count++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                fail_count++;
            end
            if (got.string_end !== want.string_end) begin
                $error("string_end: expected %0b, got %0b", want.string_end, got.string_end);
                fail_count++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn   = 1'b0;
    logic s_valid   = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready   = 1'b0;
    out_t m_payload;

    // Idle switches for the two sides; when on, each side idles with a 26 in 100 chance per draw.
    bit src_idle = 1'b1;
    bit snk_idle = 1'b1;

    url_decode_scoreboard sb;

    percent_url_decoder_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard ceiling on the run in case the block stops handshaking.
    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // The result side stalls at random while its idle switch is on.
    always @(posedge aclk) begin
        m_ready <= !snk_idle || ($urandom_range(0, 99) >= 26);
    end

    // Inputs only change at rising edges, so the values seen at the falling
    // edge are exactly those that the next rising edge will act on.
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_payload);
        end
    end

    // Presents one request, holds it until the block takes it, and then
    // hands it to the scoreboard at the edge where it was accepted.
    task automatic send_request(logic [7:0] c, logic fin);
        in_t req;
        bit  taken;
        req.char_in  = c;
        req.is_final = fin;
        while (src_idle && $urandom_range(0, 99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        sb.note_request(req);
    endtask

    // Sends a whole string; only its last byte is marked as the end.
    task automatic send_text(logic [7:0] text[$]);
        foreach (text[i]) begin
            send_request(text[i], i == text.size() - 1);
        end
    endtask

    function automatic logic [7:0] random_hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return 8'h30 + v[7:0];
        end
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v[7:0] - 8'd10;
    endfunction

    initial begin
        logic [7:0]  text[$];
        int unsigned n_tokens;
        int unsigned pick;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The first string covers plain bytes, the plus sign,
        // raw zero and 0xFF bytes, and well-formed escapes in both cases down
        // to a decoded zero byte.
        send_text('{"a", CH_PLUS, 8'h00, 8'hFF,
                    CH_PERCENT, "0", "0", CH_PERCENT, "f", "F", CH_PERCENT, "4", "a"});
        // Broken escapes: a percent sign before a non-hex byte, a percent sign
        // that restarts an escape, a held digit followed by a non-hex byte
        // (three bytes out of one request), and a held digit broken by a new
        // percent sign that is then flushed at the end of the string.
        send_text('{CH_PERCENT, "G", CH_PERCENT, CH_PERCENT, "4", "z",
                    CH_PERCENT, "4", CH_PERCENT});
        // Strings that end with an escape still open after one or two bytes.
        send_text('{CH_PERCENT});
        send_text('{CH_PERCENT, "A"});

        // Random strings. The most common tokens are well-formed escapes so that the
        // second-digit state is exercised; the rest are plus signs, broken
        // escapes and arbitrary bytes. The first stretch runs with no idling.
        src_idle = 1'b0;
        snk_idle = 1'b0;
        while (sb.request_count < 176) begin
            if (sb.request_count >= 90) begin
                src_idle = 1'b1;
                snk_idle = 1'b1;
            end
            text.delete();
            n_tokens = $urandom_range(1, 6);
            repeat (n_tokens) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    text.push_back(CH_PERCENT);
                    text.push_back(random_hex_char());
                    text.push_back(random_hex_char());
                end else if (pick < 55) begin
                    text.push_back(CH_PLUS);
                end else if (pick < 70) begin
                    text.push_back(CH_PERCENT);
                    if ($urandom_range(0, 1)) begin
                        text.push_back(random_hex_char());
                    end
                    if ($urandom_range(0, 2) != 0) begin
                        text.push_back(8'($urandom_range(0, 255)));
                    end
                end else begin
                    text.push_back(8'($urandom_range(0, 255)));
                end
            end
            send_text(text);
        end
        s_valid <= 1'b0;

        while (sb.pending_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        $display("Sent %0d requests (directed escapes, then random strings, stalls later);",
                 sb.request_count);
        $display("checked %0d decoded bytes against the predicted stream.", sb.result_count);
        if (sb.fail_count == 0 && sb.pending_bytes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
